@@ design/rtpm_pkg.sv @@
// Shared types and constants for the route table prefix match block.
// Holds status and command codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtpm_pkg;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture the incoming transfer
		logic eval;    // run the per-entry compares
		logic commit;  // update the table and load the result register
	} rtpm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free; // result register empty or being drained this cycle
	} rtpm_stat_t;

endpackage

`default_nettype wire

@@ design/rtpm_ctrl.sv @@
// Controller state machine for the route table prefix match block.
// Sequences capture, compare and commit; depends on rtpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpm_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  rtpm_pkg::rtpm_stat_t stat,
	output rtpm_pkg::rtpm_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_COMMIT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_MATCH: begin
				cmd.eval = 1'b1;
			end
			S_COMMIT: begin
				cmd.commit = stat.out_free;
				in_ready   = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.load = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_MATCH;
				end
				S_MATCH: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					// take the next transfer in the same cycle as the commit
					if (cmd.commit) state_q <= cmd.load ? S_MATCH : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/rtpm_datapath.sv @@
// Datapath for the route table prefix match block: input capture, the row of
// route entries with per-entry compare, shift insertion and the result register.
// Depends on rtpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpm_datapath #(
	parameter int DEPTH = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rtpm_pkg::rtpm_cmd_t  cmd,
	output rtpm_pkg::rtpm_stat_t stat,
	input  wire                  in_command,
	input  wire  [31:0]          in_address,
	input  wire  [31:0]          in_netmask,
	input  wire  [31:0]          in_gateway,
	input  wire  [15:0]          in_metric,
	input  wire  [7:0]           in_flags,
	input  wire  [3:0]           in_device,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [1:0]           out_status,
	output logic [31:0]          out_net,
	output logic [31:0]          out_mask,
	output logic [31:0]          out_gateway,
	output logic [15:0]          out_metric,
	output logic [7:0]           out_flags,
	output logic [3:0]           out_device
);

	localparam int CW = $clog2(DEPTH + 1);

	// captured transfer
	logic        cmd_q;
	logic [31:0] addr_q, mask_q, gw_q;
	logic [15:0] metric_q;
	logic [7:0]  flags_q;
	logic [3:0]  dev_q;

	// route entries
	logic [31:0] net_q    [DEPTH];
	logic [31:0] emask_q  [DEPTH];
	logic [31:0] egw_q    [DEPTH];
	logic [15:0] emetric_q[DEPTH];
	logic [7:0]  eflags_q [DEPTH];
	logic [3:0]  edev_q   [DEPTH];
	logic [CW-1:0] count_q;

	// compare stage
	logic [DEPTH-1:0] hit_s1, ge_s1, at_end_s1;
	logic             full_s1;

	logic [DEPTH-1:0] first_hit;
	logic [DEPTH-1:0] take_prev, take_new;
	logic [31:0] sel_net, sel_mask, sel_gw;
	logic [15:0] sel_metric;
	logic [7:0]  sel_flags;
	logic [3:0]  sel_dev;
	logic        do_insert;

	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= in_command;
			addr_q   <= in_address;
			mask_q   <= in_netmask;
			gw_q     <= in_gateway;
			metric_q <= in_metric;
			flags_q  <= in_flags;
			dev_q    <= in_device;
		end
	end

	// every valid entry compares at once; masks are sorted descending, so the
	// ge vector is a run from the insert position up to the fill level
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			for (int k = 0; k < DEPTH; k++) begin
				hit_s1[k]    <= (CW'(k) < count_q) &&
					((addr_q & emask_q[k]) == (net_q[k] & emask_q[k]));
				ge_s1[k]     <= (CW'(k) < count_q) && (mask_q >= emask_q[k]);
				at_end_s1[k] <= (CW'(k) == count_q);
			end
			full_s1 <= (count_q == CW'(DEPTH));
		end
	end

	assign first_hit = hit_s1 & (~hit_s1 + DEPTH'(1));
	assign do_insert = cmd.commit && (cmd_q == rtpm_pkg::CMD_ADD) && !full_s1;

	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			take_prev[k] = (k > 0) ? ge_s1[(k > 0) ? k - 1 : 0] : 1'b0;
			take_new[k]  = !take_prev[k] && (ge_s1[k] || at_end_s1[k]);
		end
	end

	always_comb begin
		sel_net    = '0;
		sel_mask   = '0;
		sel_gw     = '0;
		sel_metric = '0;
		sel_flags  = '0;
		sel_dev    = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (first_hit[k]) begin
				sel_net    = sel_net    | net_q[k];
				sel_mask   = sel_mask   | emask_q[k];
				sel_gw     = sel_gw     | egw_q[k];
				sel_metric = sel_metric | emetric_q[k];
				sel_flags  = sel_flags  | eflags_q[k];
				sel_dev    = sel_dev    | edev_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			for (int k = 0; k < DEPTH; k++) begin
				if (take_prev[k]) begin
					net_q[k]     <= net_q[(k > 0) ? k - 1 : 0];
					emask_q[k]   <= emask_q[(k > 0) ? k - 1 : 0];
					egw_q[k]     <= egw_q[(k > 0) ? k - 1 : 0];
					emetric_q[k] <= emetric_q[(k > 0) ? k - 1 : 0];
					eflags_q[k]  <= eflags_q[(k > 0) ? k - 1 : 0];
					edev_q[k]    <= edev_q[(k > 0) ? k - 1 : 0];
				end else if (take_new[k]) begin
					net_q[k]     <= addr_q;
					emask_q[k]   <= mask_q;
					egw_q[k]     <= gw_q;
					emetric_q[k] <= metric_q;
					eflags_q[k]  <= flags_q;
					edev_q[k]    <= dev_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (do_insert) count_q <= count_q + CW'(1);
			if (cmd.commit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (cmd_q == rtpm_pkg::CMD_LOOKUP && hit_s1 != '0) begin
				out_status  <= rtpm_pkg::ST_OK;
				out_net     <= sel_net;
				out_mask    <= sel_mask;
				out_gateway <= sel_gw;
				out_metric  <= sel_metric;
				out_flags   <= sel_flags;
				out_device  <= sel_dev;
			end else begin
				priority if (cmd_q == rtpm_pkg::CMD_LOOKUP) out_status <= rtpm_pkg::ST_MISS;
				else if (full_s1) out_status <= rtpm_pkg::ST_FULL;
				else out_status <= rtpm_pkg::ST_OK;
				out_net     <= '0;
				out_mask    <= '0;
				out_gateway <= '0;
				out_metric  <= '0;
				out_flags   <= '0;
				out_device  <= '0;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("route count above table depth");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result overwritten before transfer");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the table");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $onehot0(first_hit))
		else $error("more than one entry selected");
`endif

endmodule

`default_nettype wire

@@ design/route_table_prefix_match_top.sv @@
// Top level of the route table prefix match block.
// Instantiates rtpm_ctrl and rtpm_datapath; depends on rtpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// IPv4 route table with longest-mask-first order. Each slave transfer is a
// command: add a route (tuser = 0) or look up an address (tuser = 1). Routes
// are kept sorted by netmask, largest first; an add goes ahead of the first
// entry whose mask is not larger, so among equal masks the newest wins. A
// lookup returns the first entry where address and net agree under the
// entry's mask. Every command yields exactly one master transfer carrying a
// status in tuser (0 ok or hit, 1 miss, 2 table full) and, for a hit, the
// matched route in tdata; otherwise tdata is zero. The table is empty after
// reset. Each command first compares against all entries in parallel and
// then commits (shift-insert or select the hit into the result register).
// A new command is taken in the commit cycle, while the result register
// drains; a stalled master side holds the commit and thus the slave side.

module route_table_prefix_match_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// [31:0] address, [63:32] netmask, [95:64] gateway, [111:96] metric,
	// [119:112] route_flags, [123:120] device_id, [127:124] zero
	input  wire  [127:0] s_tdata,
	// [0] command
	input  wire  [0:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// [31:0] match_net, [63:32] match_mask, [95:64] match_gateway,
	// [111:96] match_metric, [119:112] match_flags, [123:120] match_device,
	// [127:124] zero
	output logic [127:0] m_tdata,
	// [1:0] status
	output logic [1:0]   m_tuser
);

	rtpm_pkg::rtpm_cmd_t  cmd;
	rtpm_pkg::rtpm_stat_t stat;

	logic [31:0] out_net, out_mask, out_gateway;
	logic [15:0] out_metric;
	logic [7:0]  out_flags;
	logic [3:0]  out_device;

	rtpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rtpm_datapath #(
		.DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_command  (s_tuser[0]),
		.in_address  (s_tdata[31:0]),
		.in_netmask  (s_tdata[63:32]),
		.in_gateway  (s_tdata[95:64]),
		.in_metric   (s_tdata[111:96]),
		.in_flags    (s_tdata[119:112]),
		.in_device   (s_tdata[123:120]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (m_tuser),
		.out_net     (out_net),
		.out_mask    (out_mask),
		.out_gateway (out_gateway),
		.out_metric  (out_metric),
		.out_flags   (out_flags),
		.out_device  (out_device)
	);

	// pack the result fields, padding the top nibble with zeros
	assign m_tdata = {4'b0, out_device, out_flags, out_metric,
		out_gateway, out_mask, out_net};

endmodule

`default_nettype wire
